/* src/bmph_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmph_pkg
// Shared types and constants of the peak-hold bar meter.
// ----------------------------------------------------------------------------
package bmph_pkg;

   localparam int BANDS      = 24;
   localparam int BAND_W     = 5;
   localparam int IDX_W      = $clog2(BANDS);
   localparam int LEVEL_W    = 16;
   localparam int HOLD_W     = 4;
   localparam int PLOT_W     = 10;
   localparam int CAP_W      = 4;
   localparam int BAR_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD_TICKS  = 2'd0,
      CSR_FALL_STEP   = 2'd1,
      CSR_PLOT_HEIGHT = 2'd2,
      CSR_CAP_HEIGHT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [HOLD_W-1:0]  hold_ticks;
      logic [LEVEL_W-1:0] fall_step;
      logic [PLOT_W-1:0]  plot_height;
      logic [CAP_W-1:0]   cap_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hold_ticks:  4'd12,
      fall_step:   16'd983,
      plot_height: 10'd100,
      cap_height:  4'd3
   };

   // updated band levels handed to the output stage
   typedef struct packed {
      logic [BAND_W-1:0]  band;
      logic [LEVEL_W-1:0] smoothed;
      logic [LEVEL_W-1:0] peak;
   } meter_type;

endpackage
`default_nettype wire

/* src/bmph_band_state.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmph_band_state
// Per-band smoothed level, peak and hold counter with combinational read-modify-write update.
// ----------------------------------------------------------------------------
module bmph_band_state (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          upd_en,
   input  wire [bmph_pkg::BAND_W-1:0]   band_i,
   input  wire [bmph_pkg::LEVEL_W-1:0]  level_i,
   input  bmph_pkg::cfg_type            cfg_i,
   output bmph_pkg::meter_type          meter_o
);
   import bmph_pkg::*;

   // ceil(d/5) = floor((d+4)/5), by reciprocal for d below 2^17
   localparam logic [16:0] DIV5_MUL   = 17'd104858;
   localparam int          DIV5_SHIFT = 19;
   localparam logic [BAND_W:0] BANDS_LIM = (BAND_W+1)'(BANDS);

   logic [LEVEL_W-1:0] smoothed_ff [BANDS];
   logic [LEVEL_W-1:0] peak_ff     [BANDS];
   logic [HOLD_W-1:0]  hold_ff     [BANDS];

   logic               in_range;
   logic [IDX_W-1:0]   idx;
   logic [LEVEL_W-1:0] s_old;
   logic [LEVEL_W-1:0] pk_old;
   logic [HOLD_W-1:0]  hold_old;
   logic [LEVEL_W-1:0] diff;
   logic [16:0]        diff_rnd;
   logic [33:0]        quot_prod;
   logic [LEVEL_W-1:0] quot;
   logic [LEVEL_W-1:0] s_new;
   logic [LEVEL_W-1:0] pk_fall;
   logic [LEVEL_W-1:0] pk_new;
   logic [HOLD_W-1:0]  hold_new;

   assign in_range = {1'b0, band_i} < BANDS_LIM;
   assign idx      = band_i[IDX_W-1:0];

   always_comb begin
      s_old    = '0;
      pk_old   = '0;
      hold_old = '0;
      if (in_range) begin
         s_old    = smoothed_ff[idx];
         pk_old   = peak_ff[idx];
         hold_old = hold_ff[idx];
      end
   end

   // release: 0.8*old + 0.2*new = old - ceil((old - new)/5)
   always_comb begin
      diff      = s_old - level_i;
      diff_rnd  = {1'b0, diff} + 17'd4;
      quot_prod = diff_rnd * DIV5_MUL;
      quot      = LEVEL_W'(quot_prod >> DIV5_SHIFT);
      if (level_i > s_old) begin
         s_new = level_i;
      end else begin
         s_new = s_old - quot;
      end
   end

   always_comb begin
      pk_fall  = (pk_old > cfg_i.fall_step) ? pk_old - cfg_i.fall_step : '0;
      pk_new   = pk_old;
      hold_new = hold_old;
      if (s_new >= pk_old) begin
         pk_new   = s_new;
         hold_new = cfg_i.hold_ticks;
      end else if (hold_old != '0) begin
         hold_new = hold_old - 1'b1;
      end else begin
         pk_new = (pk_fall < s_new) ? s_new : pk_fall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BANDS; i++) begin
            smoothed_ff[i] <= '0;
            peak_ff[i]     <= '0;
            hold_ff[i]     <= '0;
         end
      end else if (upd_en && in_range) begin
         smoothed_ff[idx] <= s_new;
         peak_ff[idx]     <= pk_new;
         hold_ff[idx]     <= hold_new;
      end
   end

   // out-of-range bands report as empty
   always_comb begin
      meter_o.band     = band_i;
      meter_o.smoothed = in_range ? s_new : '0;
      meter_o.peak     = in_range ? pk_new : '0;
   end

endmodule
`default_nettype wire

/* src/bar_meter_peak_hold.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bar_meter_peak_hold
// Peak-hold bar meter: per-band smoothing, peak hold and fall, bar and cap
// position for display.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req_     in   band, level
//  rsp_     out  band_out, bar_percent, cap_top
//  csr_     in   index, data (register write)
//
//  one beat per cycle sustained while rsp_ is not stalled
//  stages: input register, band update, output register
//  band read-modify-write is combinational and written back as the beat leaves
//  the input register, so repeated bands follow back to back
//  req_ready drops only when rsp_ is stalled and all three stages are full
//  reset clears every band; csr_ready is always high
// ----------------------------------------------------------------------------
module bar_meter_peak_hold (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [bmph_pkg::BAND_W-1:0]      req_band,
   input  wire [bmph_pkg::LEVEL_W-1:0]     req_level,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [bmph_pkg::BAND_W-1:0]     rsp_band_out,
   output logic [bmph_pkg::BAR_W-1:0]      rsp_bar_percent,
   output logic [bmph_pkg::PLOT_W-1:0]     rsp_cap_top,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [bmph_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [bmph_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bmph_pkg::*;

   // floor(y / 65535) for y below 2^32 - 2^16
   function automatic logic [15:0] div_full_scale(input logic [31:0] y);
      logic [32:0] sum;
      sum = {1'b0, y} + 33'(y >> 16) + 33'd1;
      return sum[31:16];
   endfunction

   cfg_type            cfg_ff, cfg_in;

   logic               in_vld_ff, in_vld_in;
   logic [BAND_W-1:0]  in_band_ff;
   logic [LEVEL_W-1:0] in_level_ff;

   logic               mid_vld_ff, mid_vld_in;
   meter_type          mid_ff;
   meter_type          meter;

   logic               out_vld_ff, out_vld_in;
   logic [BAND_W-1:0]  out_band_ff;
   logic [BAR_W-1:0]   out_bar_ff, out_bar_in;
   logic [PLOT_W-1:0]  out_cap_ff, out_cap_in;

   logic               out_take;
   logic               mid_take;
   logic               in_take;

   logic [31:0]        bar_scaled;
   logic [15:0]        bar_q;
   logic [31:0]        cap_prod;
   logic [15:0]        cap_q;
   logic [11:0]        cap_diff;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_HOLD_TICKS:  cfg_in.hold_ticks  = csr_data[HOLD_W-1:0];
            CSR_FALL_STEP:   cfg_in.fall_step   = csr_data[LEVEL_W-1:0];
            CSR_PLOT_HEIGHT: cfg_in.plot_height = csr_data[PLOT_W-1:0];
            CSR_CAP_HEIGHT:  cfg_in.cap_height  = csr_data[CAP_W-1:0];
         endcase
      end
   end

   // pipeline flow
   assign out_take  = !out_vld_ff || rsp_ready;
   assign mid_take  = !mid_vld_ff || out_take;
   assign in_take   = !in_vld_ff || mid_take;
   assign req_ready = in_take;

   assign in_vld_in  = in_take  ? req_valid  : in_vld_ff;
   assign mid_vld_in = mid_take ? in_vld_ff  : mid_vld_ff;
   assign out_vld_in = out_take ? mid_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= CFG_RESET;
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         mid_vld_ff <= mid_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_band_ff  <= req_band;
         in_level_ff <= req_level;
      end
      if (mid_take) begin
         mid_ff <= meter;
      end
      if (out_take) begin
         out_band_ff <= mid_ff.band;
         out_bar_ff  <= out_bar_in;
         out_cap_ff  <= out_cap_in;
      end
   end

   // band update
   bmph_band_state u_band_state (
      .clock   (clock),
      .reset   (reset),
      .upd_en  (in_vld_ff && mid_take),
      .band_i  (in_band_ff),
      .level_i (in_level_ff),
      .cfg_i   (cfg_ff),
      .meter_o (meter)
   );

   // bar height and cap row
   always_comb begin
      bar_scaled = (32'(mid_ff.smoothed) << 6) + (32'(mid_ff.smoothed) << 5);
      bar_q      = div_full_scale(bar_scaled);
      out_bar_in = BAR_W'(2) + bar_q[BAR_W-1:0];

      cap_prod   = 32'(mid_ff.peak) * 32'(cfg_ff.plot_height);
      cap_q      = div_full_scale(cap_prod);
      cap_diff   = {2'b00, cfg_ff.plot_height} - {2'b00, cap_q[PLOT_W-1:0]}
                 - {8'b0, cfg_ff.cap_height};
      out_cap_in = cap_diff[11] ? '0 : cap_diff[PLOT_W-1:0];
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_band_out    = out_band_ff;
   assign rsp_bar_percent = out_bar_ff;
   assign rsp_cap_top     = out_cap_ff;

endmodule
`default_nettype wire

/* src/bmph_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmph_checker
// Port-level checks of the peak-hold bar meter, bound to the top level.
// ----------------------------------------------------------------------------
module bmph_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_ready,
   input  wire                             rsp_valid,
   input  wire                             rsp_ready,
   input  wire [bmph_pkg::BAND_W-1:0]      rsp_band_out,
   input  wire [bmph_pkg::BAR_W-1:0]       rsp_bar_percent,
   input  wire [bmph_pkg::PLOT_W-1:0]      rsp_cap_top
);
   import bmph_pkg::*;

   localparam logic [BAND_W:0] BANDS_LIM = (BAND_W+1)'(BANDS);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_band_out)
         && $stable(rsp_bar_percent) && $stable(rsp_cap_top))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_bar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bar_percent >= BAR_W'(2) && rsp_bar_percent <= BAR_W'(98))
      else $error("bar_percent out of range");

   a_oob_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({1'b0, rsp_band_out} >= BANDS_LIM) |-> rsp_bar_percent == BAR_W'(2))
      else $error("unknown band shows a bar");

   // pipeline only backs up behind a stalled result
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

endmodule

bind bar_meter_peak_hold bmph_checker u_bmph_checker (.*);
`default_nettype wire

/* dv/tb_bar_meter_peak_hold.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bar_meter_peak_hold
// Self-checking bench for the peak-hold bar meter. A scoreboard keeps its own
// per-band smoothed level, peak and hold count, works out bar height and cap
// row for every accepted request beat and compares them in order with the
// response beats. Register settings change between phases, including the
// extremes, with random gaps on both channels, a long response stall and a
// full drain part way through.
// ----------------------------------------------------------------------------
module tb_bar_meter_peak_hold;
   import bmph_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 250;

   typedef struct {
      bit [BAND_W-1:0] band;
      bit [BAR_W-1:0]  bar;
      bit [PLOT_W-1:0] cap;
   } meter_reading_type;

   class meter_scoreboard;
      bit [HOLD_W-1:0]  hold_ticks;
      bit [LEVEL_W-1:0] fall_step;
      bit [PLOT_W-1:0]  plot_height;
      bit [CAP_W-1:0]   cap_height;
      bit [LEVEL_W-1:0] smoothed [BANDS];
      bit [LEVEL_W-1:0] peak [BANDS];
      bit [HOLD_W-1:0]  hold_left [BANDS];
      meter_reading_type awaited [$];
      int               errors;

      function new();
         hold_ticks  = 4'd12;
         fall_step   = 16'd983;
         plot_height = 10'd100;
         cap_height  = 4'd3;
         errors      = 0;
         for (int i = 0; i < BANDS; i++) begin
            smoothed[i]  = '0;
            peak[i]      = '0;
            hold_left[i] = '0;
         end
      endfunction

      function void set_register(csr_index_type idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HOLD_TICKS:  hold_ticks  = data[HOLD_W-1:0];
            CSR_FALL_STEP:   fall_step   = data[LEVEL_W-1:0];
            CSR_PLOT_HEIGHT: plot_height = data[PLOT_W-1:0];
            CSR_CAP_HEIGHT:  cap_height  = data[CAP_W-1:0];
            default: ;
         endcase
      endfunction

      function bit [PLOT_W-1:0] cap_row(bit [LEVEL_W-1:0] pk);
         int h;
         int c;
         int scaled;
         int row;
         h      = int'(plot_height);
         c      = int'(cap_height);
         scaled = int'((longint'(pk) * longint'(plot_height)) / 65535);
         row    = h - scaled - c;
         if (row > h - c) row = h - c;
         if (row < 0) row = 0;
         return row[PLOT_W-1:0];
      endfunction

      function void note_request(bit [BAND_W-1:0] band, bit [LEVEL_W-1:0] level);
         meter_reading_type r;
         int unsigned    s;
         int unsigned    pk;
         r.band = band;
         if (int'(band) >= BANDS) begin
            r.bar = 7'd2;
            r.cap = cap_row('0);
         end else begin
            s = smoothed[band];
            if (level > s) s = level;
            else s = (4 * s + level) / 5;
            smoothed[band] = s[LEVEL_W-1:0];
            pk = peak[band];
            if (s >= pk) begin
               pk = s;
               hold_left[band] = hold_ticks;
            end else if (hold_left[band] != 0) begin
               hold_left[band] = hold_left[band] - 1'b1;
            end else begin
               pk = (pk > fall_step) ? pk - fall_step : 0;
               if (pk < s) pk = s;
            end
            peak[band] = pk[LEVEL_W-1:0];
            r.bar = 7'(2 + (s * 96) / 65535);
            r.cap = cap_row(pk[LEVEL_W-1:0]);
         end
         awaited.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(bit [BAND_W-1:0] band, bit [BAR_W-1:0] bar,
                          bit [PLOT_W-1:0] cap);
         meter_reading_type r;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected beat band %0d bar %0d cap %0d", band, bar, cap));
         end else begin
            r = awaited.pop_front();
            if (band !== r.band)
               report($sformatf("band_out %0d, want %0d", band, r.band));
            if (bar !== r.bar)
               report($sformatf("bar_percent %0d, want %0d (band %0d)", bar, r.bar, r.band));
            if (cap !== r.cap)
               report($sformatf("cap_top %0d, want %0d (band %0d)", cap, r.cap, r.band));
         end
      endtask

      task flush_leftovers();
         if (awaited.size() != 0)
            report($sformatf("%0d beats never came out", awaited.size()));
      endtask

      function int depth();
         return awaited.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [BAND_W-1:0]     req_band;
   logic [LEVEL_W-1:0]    req_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [BAND_W-1:0]     rsp_band_out;
   logic [BAR_W-1:0]      rsp_bar_percent;
   logic [PLOT_W-1:0]     rsp_cap_top;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   meter_scoreboard sb;
   bit              steady;
   int              rsp_hold_off;
   int              cycles;
   bit [BAND_W-1:0] hot_band [3];

   bar_meter_peak_hold uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_band        (req_band),
      .req_level       (req_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_band_out    (rsp_band_out),
      .rsp_bar_percent (rsp_bar_percent),
      .rsp_cap_top     (rsp_cap_top),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // called on a falling edge, returns on the falling edge after the beat
   task automatic send_beat(bit [BAND_W-1:0] band, bit [LEVEL_W-1:0] level);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_band  = band;
      req_level = level;
      do @(posedge clock); while (!req_ready);
      sb.note_request(band, level);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.depth() != 0) @(negedge clock);
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic load_settings(bit [HOLD_W-1:0] hold, bit [LEVEL_W-1:0] fall,
                                bit [PLOT_W-1:0] plot, bit [CAP_W-1:0] cap);
      bit [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom_range(65535));
      write_csr(CSR_HOLD_TICKS, {junk[15:HOLD_W], hold});
      write_csr(CSR_FALL_STEP, fall);
      write_csr(CSR_PLOT_HEIGHT, {junk[15:PLOT_W], plot});
      write_csr(CSR_CAP_HEIGHT, {junk[CAP_W +: 12], cap});
   endtask

   task automatic pick_beat(output bit [BAND_W-1:0] band, output bit [LEVEL_W-1:0] level);
      int r;
      r = $urandom_range(99);
      if (r < 6) band = BAND_W'($urandom_range(31, BANDS));
      else if (r < 70) band = hot_band[$urandom_range(2)];
      else band = BAND_W'($urandom_range(BANDS - 1));
      r = $urandom_range(99);
      if (r < 8) level = 16'hFFFF;
      else if (r < 35) level = '0;
      else if (r < 55) level = LEVEL_W'($urandom_range(65535));
      else level = LEVEL_W'($urandom_range(8191));
   endtask

   initial begin
      rsp_ready = 1'b0;
      if (rsp_hold_off < 0) rsp_hold_off = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_off > 0) begin
            rsp_ready    = 1'b0;
            rsp_hold_off = rsp_hold_off - 1;
         end else begin
            rsp_ready = steady || ($urandom_range(99) >= 7);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_band_out, rsp_bar_percent, rsp_cap_top);
         @(negedge clock);
      end
   end

   initial begin
      bit [BAND_W-1:0]  b;
      bit [LEVEL_W-1:0] l;
      sb           = new();
      steady       = 1'b0;
      rsp_hold_off = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_band     = '0;
      req_level    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_HOLD_TICKS;
      csr_data     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // full scale attack, then release through hold into the fall
      send_beat(5'd0, 16'hFFFF);
      repeat (14) send_beat(5'd0, 16'h0000);
      send_beat(BAND_W'(BANDS - 1), 16'h0001);
      send_beat(BAND_W'(BANDS - 1), 16'h0000);
      // bands past the last bar
      send_beat(BAND_W'(BANDS), 16'hFFFF);
      send_beat(5'd31, 16'h5A5A);
      send_beat(5'd5, 16'h8000);
      send_beat(5'd5, 16'h9C40);
      send_beat(5'd5, 16'h8000);
      send_beat(5'd1, 16'h0000);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: load_settings(4'd0, 16'hFFFF, 10'd1023, 4'd0);
            1: load_settings(4'd15, 16'd0, 10'd10, 4'd15);
            2: load_settings(4'd3, 16'd983, 10'd5, 4'd15);
            4: load_settings(4'd1, 16'd1, 10'd0, 4'd0);
            6: load_settings(4'd12, 16'd4000, 10'd100, 4'd3);
            default: load_settings(HOLD_W'($urandom_range(15)),
                                   LEVEL_W'($urandom_range(65535)),
                                   PLOT_W'($urandom_range(1023)),
                                   CAP_W'($urandom_range(15)));
         endcase
         for (int i = 0; i < 3; i++) hot_band[i] = BAND_W'($urandom_range(BANDS - 1));
         steady = (p == 3);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (p == 5 && i == 100) rsp_hold_off = 60;
            if (p == 6 && i == 120) drain();
            pick_beat(b, l);
            send_beat(b, l);
         end
      end

      drain();
      repeat (10) @(negedge clock);
      sb.flush_leftovers();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
